// ===== design/vdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// vdsa_pkg
// Shared types, constants and the arctangent table for the view direction to
// spherical angles pipeline.
// ----------------------------------------------------------------------------
package vdsa_pkg;

  // Defaults of the top-level parameters.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 32;

  // Normalized coordinates have their largest magnitude in [2^29, 2^30).
  localparam int NORM_MSB = 29;
  // Rotator datapath width; covers the CORDIC gain on a normalized vector.
  localparam int VEC_W = 34;
  // Angle accumulator in units of 2^-24 turn.
  localparam int ANGLE_W = 26;
  localparam int ANGLE_FRAC = 8;
  localparam int OUT_ANGLE_W = 16;
  localparam int THETA_W = ANGLE_W - ANGLE_FRAC;

  localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_TURN = 26'sd8388608;
  localparam logic signed [ANGLE_W:0]   ANGLE_ROUND     = 27'sd128;
  localparam logic signed [THETA_W-1:0] THETA_MAX       = 18'sd32768;

  // Inverse CORDIC gain, Q30.
  localparam int GAIN_FRAC = 30;
  localparam logic [GAIN_FRAC-1:0] INV_GAIN_Q30 = 30'd652032874;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2
  } cfg_index_t;

  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // Side band that travels with the planar (x, y) rotation.
  typedef struct packed {
    logic degenerate;
    logic zero_xy;
    vec_t dz;
  } pass1_side_t;

  // Side band that travels with the polar rotation.
  typedef struct packed {
    logic   degenerate;
    angle_t phi;
  } pass2_side_t;

  // atan(2^-i) in units of 2^-24 turn, rounded to nearest.
  function automatic angle_t atan_rom(input int unsigned idx);
    angle_t val;
    case (idx)
      0:       val = 26'sd2097152;
      1:       val = 26'sd1238021;
      2:       val = 26'sd654136;
      3:       val = 26'sd332050;
      4:       val = 26'sd166669;
      5:       val = 26'sd83416;
      6:       val = 26'sd41718;
      7:       val = 26'sd20860;
      8:       val = 26'sd10430;
      9:       val = 26'sd5215;
      10:      val = 26'sd2608;
      11:      val = 26'sd1304;
      12:      val = 26'sd652;
      13:      val = 26'sd326;
      14:      val = 26'sd163;
      15:      val = 26'sd81;
      16:      val = 26'sd41;
      17:      val = 26'sd20;
      18:      val = 26'sd10;
      19:      val = 26'sd5;
      20:      val = 26'sd3;
      21:      val = 26'sd1;
      22:      val = 26'sd1;
      default: val = 26'sd0;
    endcase
    return val;
  endfunction

endpackage

// ===== design/vdsa_norm.sv =====
// ----------------------------------------------------------------------------
// vdsa_norm
// Subtracts the camera center and scales the direction by a common power of
// two so that its largest component magnitude lies in [2^29, 2^30).
// ----------------------------------------------------------------------------
module vdsa_norm import vdsa_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_z_i,
  output logic                          valid_o,
  output vec_t                          x_o,
  output vec_t                          y_o,
  output pass1_side_t                   side_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = $clog2(DW);
  localparam int WW = DW + NORM_MSB;

  // Stage 1: differences.
  logic                 v1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dz1_r;

  // Stage 2: OR of magnitudes has the same leading one as their maximum.
  logic                 v2_r;
  logic signed [DW-1:0] dx2_r, dy2_r, dz2_r;
  logic [DW-1:0]        mag_or_r;
  logic [DW-1:0]        mag_x, mag_y, mag_z, mag_or_nxt;

  // Stage 3: leading one position.
  logic                 v3_r;
  logic signed [DW-1:0] dx3_r, dy3_r, dz3_r;
  logic [PW-1:0]        msb_r, msb_nxt;
  logic                 deg3_r;

  // Stage 4: scaled output.
  logic                 v4_r;
  vec_t                 nx_r, ny_r;
  pass1_side_t          side_r;
  logic signed [WW-1:0] wide_x, wide_y, wide_z;
  vec_t                 nx_nxt, ny_nxt, nz_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r <= {point_x_i[COORD_WIDTH-1], point_x_i} - {center_x_i[COORD_WIDTH-1], center_x_i};
    dy1_r <= {point_y_i[COORD_WIDTH-1], point_y_i} - {center_y_i[COORD_WIDTH-1], center_y_i};
    dz1_r <= {point_z_i[COORD_WIDTH-1], point_z_i} - {center_z_i[COORD_WIDTH-1], center_z_i};
  end

  always_comb begin
    mag_x      = dx1_r[DW-1] ? DW'(-dx1_r) : DW'(dx1_r);
    mag_y      = dy1_r[DW-1] ? DW'(-dy1_r) : DW'(dy1_r);
    mag_z      = dz1_r[DW-1] ? DW'(-dz1_r) : DW'(dz1_r);
    mag_or_nxt = mag_x | mag_y | mag_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx2_r    <= dx1_r;
    dy2_r    <= dy1_r;
    dz2_r    <= dz1_r;
    mag_or_r <= mag_or_nxt;
  end

  always_comb begin
    msb_nxt = '0;
    for (int i = 0; i < DW; i++) begin
      if (mag_or_r[i]) begin
        msb_nxt = PW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dx3_r  <= dx2_r;
    dy3_r  <= dy2_r;
    dz3_r  <= dz2_r;
    msb_r  <= msb_nxt;
    deg3_r <= (mag_or_r == '0);
  end

  // Multiplying by 2^29 and shifting right by the leading one position gives
  // an exact left shift or a floor right shift in one shifter.
  always_comb begin
    wide_x = $signed({dx3_r, {NORM_MSB{1'b0}}});
    wide_y = $signed({dy3_r, {NORM_MSB{1'b0}}});
    wide_z = $signed({dz3_r, {NORM_MSB{1'b0}}});
    nx_nxt = VEC_W'(wide_x >>> msb_r);
    ny_nxt = VEC_W'(wide_y >>> msb_r);
    nz_nxt = VEC_W'(wide_z >>> msb_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    nx_r              <= nx_nxt;
    ny_r              <= ny_nxt;
    side_r.dz         <= nz_nxt;
    side_r.degenerate <= deg3_r;
    side_r.zero_xy    <= (nx_nxt == '0) && (ny_nxt == '0);
  end

  assign valid_o = v4_r;
  assign x_o     = nx_r;
  assign y_o     = ny_r;
  assign side_o  = side_r;

endmodule

// ===== design/vdsa_cell.sv =====
// ----------------------------------------------------------------------------
// vdsa_cell
// One CORDIC vectoring micro-rotation: turns the vector toward the +x axis by
// atan(2^-STAGE) and accumulates the angle, then registers the result.
// ----------------------------------------------------------------------------
module vdsa_cell import vdsa_pkg::*; #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  vec_t              x_i,
  input  vec_t              y_i,
  input  angle_t            z_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output vec_t              x_o,
  output vec_t              y_o,
  output angle_t            z_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam angle_t ATAN_STEP = atan_rom(STAGE);

  logic              valid_r;
  vec_t              x_r, y_r, x_nxt, y_nxt, xs, ys;
  angle_t            z_r, z_nxt;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[VEC_W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN_STEP;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    side_r <= side_i;
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign side_o  = side_r;

endmodule

// ===== design/vdsa_pass.sv =====
// ----------------------------------------------------------------------------
// vdsa_pass
// One vectoring pass: a quadrant fold into the right half plane followed by a
// chain of micro-rotation cells, one item entering per clock.
// ----------------------------------------------------------------------------
module vdsa_pass import vdsa_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  vec_t              x_i,
  input  vec_t              y_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output vec_t              x_o,
  output angle_t            z_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_s    [0:STAGES];
  vec_t              x_s    [0:STAGES];
  vec_t              y_s    [0:STAGES];
  angle_t            z_s    [0:STAGES];
  logic [SIDE_W-1:0] side_s [0:STAGES];

  logic              pre_valid_r;
  vec_t              pre_x_r, pre_y_r, pre_x_nxt, pre_y_nxt;
  angle_t            pre_z_r, pre_z_nxt;
  logic [SIDE_W-1:0] pre_side_r;

  // A vector in the left half plane is turned by a half turn first.
  always_comb begin
    if (x_i[VEC_W-1]) begin
      pre_x_nxt = -x_i;
      pre_y_nxt = -y_i;
      pre_z_nxt = y_i[VEC_W-1] ? -ANGLE_HALF_TURN : ANGLE_HALF_TURN;
    end else begin
      pre_x_nxt = x_i;
      pre_y_nxt = y_i;
      pre_z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else begin
      pre_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    pre_x_r    <= pre_x_nxt;
    pre_y_r    <= pre_y_nxt;
    pre_z_r    <= pre_z_nxt;
    pre_side_r <= side_i;
  end

  assign v_s[0]    = pre_valid_r;
  assign x_s[0]    = pre_x_r;
  assign y_s[0]    = pre_y_r;
  assign z_s[0]    = pre_z_r;
  assign side_s[0] = pre_side_r;

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    vdsa_cell #(
      .STAGE  (g),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (v_s[g]),
      .x_i     (x_s[g]),
      .y_i     (y_s[g]),
      .z_i     (z_s[g]),
      .side_i  (side_s[g]),
      .valid_o (v_s[g+1]),
      .x_o     (x_s[g+1]),
      .y_o     (y_s[g+1]),
      .z_o     (z_s[g+1]),
      .side_o  (side_s[g+1])
    );
  end

  assign valid_o = v_s[STAGES];
  assign x_o     = x_s[STAGES];
  assign z_o     = z_s[STAGES];
  assign side_o  = side_s[STAGES];

endmodule

// ===== design/view_direction_to_spherical_angles_core.sv =====
// ----------------------------------------------------------------------------
// view_direction_to_spherical_angles_core
// Converts a 3D point, relative to a programmable camera center, into polar
// and azimuth angles in binary angle units (65536 per turn).
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write center_x, center_y and center_z through cfg_we,
//   cfg_index and cfg_wdata while no request is in flight. Reset clears all
//   three to zero. Writes to an unused index are dropped.
//   Requests: drive in_point_x/y/z and pulse start. busy is always low, so a
//   request is taken on every clock edge with start high, back to back.
//   Results: out_valid is high for one cycle with out_polar_angle,
//   out_azimuth_angle and out_degenerate. The receiver cannot stall, so each
//   result must be captured in that cycle.
//   Pipeline: the path is four normalization stages, two chains of
//   CORDIC_STAGES rotation cells with a fold stage each, one gain multiply
//   stage and the output register.
//   Throughput is one request per clock.
//   A point equal to the center gives out_degenerate high and zero angles.
//   Reset clears all valid bits; requests in flight are lost.
// ----------------------------------------------------------------------------
module view_direction_to_spherical_angles_core import vdsa_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  output logic                          out_valid,
  output logic [OUT_ANGLE_W-1:0]        out_polar_angle,
  output logic signed [OUT_ANGLE_W-1:0] out_azimuth_angle,
  output logic                          out_degenerate
);

  localparam int P1_W = $bits(pass1_side_t);
  localparam int P2_W = $bits(pass2_side_t);
  localparam int PROD_W = VEC_W + GAIN_FRAC;

  logic signed [COORD_WIDTH-1:0] center_x_r, center_y_r, center_z_r;

  logic        n_valid;
  vec_t        n_x, n_y;
  pass1_side_t n_side;

  logic        p1_valid;
  vec_t        p1_x;
  angle_t      p1_z;
  logic [P1_W-1:0] p1_side_bits;
  pass1_side_t p1_side;

  logic        m_valid_r;
  vec_t        m_r_r, m_dz_r;
  pass2_side_t m_side_r;
  logic [PROD_W-1:0] prod;
  vec_t        r_nxt;

  logic        p2_valid;
  angle_t      p2_z;
  logic [P2_W-1:0] p2_side_bits;
  pass2_side_t p2_side;

  logic signed [ANGLE_W:0]   theta_rnd, phi_rnd;
  logic signed [THETA_W-1:0] theta_t;
  logic [OUT_ANGLE_W-1:0]    polar_nxt;
  logic signed [OUT_ANGLE_W-1:0] azim_nxt;

  logic                          out_valid_r;
  logic [OUT_ANGLE_W-1:0]        polar_r;
  logic signed [OUT_ANGLE_W-1:0] azim_r;
  logic                          deg_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x_r <= cfg_wdata;
        CFG_CENTER_Y: center_y_r <= cfg_wdata;
        CFG_CENTER_Z: center_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vdsa_norm #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (start),
    .point_x_i  (in_point_x),
    .point_y_i  (in_point_y),
    .point_z_i  (in_point_z),
    .center_x_i (center_x_r),
    .center_y_i (center_y_r),
    .center_z_i (center_z_r),
    .valid_o    (n_valid),
    .x_o        (n_x),
    .y_o        (n_y),
    .side_o     (n_side)
  );

  // Azimuth pass on (dx, dy).
  vdsa_pass #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (P1_W)
  ) u_pass_azim (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (n_valid),
    .x_i     (n_x),
    .y_i     (n_y),
    .side_i  (n_side),
    .valid_o (p1_valid),
    .x_o     (p1_x),
    .z_o     (p1_z),
    .side_o  (p1_side_bits)
  );

  assign p1_side = pass1_side_t'(p1_side_bits);

  // Planar length: the rotated x is non-negative, so an unsigned product works.
  assign prod  = {{GAIN_FRAC{1'b0}}, p1_x} * {{VEC_W{1'b0}}, INV_GAIN_Q30};
  assign r_nxt = vec_t'(prod[PROD_W-1:GAIN_FRAC]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= p1_valid;
    end
  end

  // A direction along the z axis has no azimuth and no planar length.
  always_ff @(posedge clk) begin
    m_dz_r              <= p1_side.dz;
    m_side_r.degenerate <= p1_side.degenerate;
    m_r_r               <= p1_side.zero_xy ? '0 : r_nxt;
    m_side_r.phi        <= p1_side.zero_xy ? '0 : p1_z;
  end

  // Polar pass on (dz, planar length).
  vdsa_pass #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (P2_W)
  ) u_pass_polar (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (m_valid_r),
    .x_i     (m_dz_r),
    .y_i     (m_r_r),
    .side_i  (m_side_r),
    .valid_o (p2_valid),
    .x_o     (),
    .z_o     (p2_z),
    .side_o  (p2_side_bits)
  );

  assign p2_side = pass2_side_t'(p2_side_bits);

  always_comb begin
    theta_rnd = {p2_z[ANGLE_W-1], p2_z} + ANGLE_ROUND;
    phi_rnd   = {p2_side.phi[ANGLE_W-1], p2_side.phi} + ANGLE_ROUND;
    theta_t   = THETA_W'(theta_rnd >>> ANGLE_FRAC);
    if (theta_t[THETA_W-1]) begin
      polar_nxt = '0;
    end else if (theta_t > THETA_MAX) begin
      polar_nxt = OUT_ANGLE_W'(THETA_MAX);
    end else begin
      polar_nxt = theta_t[OUT_ANGLE_W-1:0];
    end
    azim_nxt = phi_rnd[ANGLE_FRAC +: OUT_ANGLE_W];
    if (p2_side.degenerate) begin
      polar_nxt = '0;
      azim_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    polar_r <= polar_nxt;
    azim_r  <= azim_nxt;
    deg_r   <= p2_side.degenerate;
  end

  assign out_valid         = out_valid_r;
  assign out_polar_angle   = polar_r;
  assign out_azimuth_angle = azim_r;
  assign out_degenerate    = deg_r;

endmodule
